@@ rtl/core/lrpc_pkg.sv @@
package lrpc_pkg;

   // Field and register widths
   localparam int RANGE_W = 16;
   localparam int INDEX_W = 12;
   localparam int POS_W   = 17;
   localparam int PPS_W   = 13;
   localparam int START_W = 17;
   localparam int CSR_W   = 17;

   // Beam angle arithmetic
   localparam int FULL_TURN     = 36000;
   localparam int HALF_TURN     = 18000;
   localparam int QUARTER_TURN  = 9000;
   localparam int THREE_QUARTER = 27000;
   localparam int NUM_W  = 28;          // 36000 * 4095 fits in 28 bits
   localparam int REM_W  = PPS_W + 1;
   localparam int ANG_W  = 30;          // signed, unwrapped angle
   localparam int MOD_W  = 29;          // angle shifted to be non-negative
   localparam int MOD_STEPS = 14;       // 36000 * 2^14 exceeds any shifted angle
   localparam int T_W    = 16;          // folded angle, signed

   // Range limits in millimetres
   localparam int ROI_LIMIT_WIDE   = 2000;
   localparam int ROI_LIMIT_NARROW = 1400;
   localparam int WIDE_LIMIT       = 2500;

   // CORDIC datapath
   localparam int Z_W     = 32;
   localparam int XY_W    = 36;
   localparam int GAIN_W  = 30;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
   localparam int PROD_W  = RANGE_W + GAIN_W;
   localparam int X0_W    = PROD_W - 14;
   localparam int OUT_MAX = 65535;
   localparam int TAB_LEN = 24;

   // atan(2^-i) in centidegrees with 16 fraction bits
   localparam int ATAN_TAB [TAB_LEN] = '{
      294912000, 174096719, 91987925, 46694507,
      23437865, 11730358, 5866610, 2933484,
      1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459,
      5730, 2865, 1432, 716,
      358, 179, 90, 45
   };

   typedef enum logic [1:0] {
      CSR_MIN_RANGE   = 2'd0,
      CSR_WIDE_MODE   = 2'd1,
      CSR_PPS         = 2'd2,
      CSR_ANGLE_START = 2'd3
   } csr_index_type;

   // Side data that travels with a beam through every cell
   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic               last;
      logic               roi_ok;
      logic               wide_ok;
      logic               negate;
   } tag_type;

endpackage

@@ rtl/core/lidar_roi_polar_to_cartesian.sv @@
// Throughput: one word per cycle when the result side does not stall.
// Every stage holds one beam and hands it on each cycle unless a result-side stall holds it.
// A stall on the result side only holds stages that are full, so empty stages keep accepting.
// Reset is synchronous and active high; it empties the pipeline and restores the register defaults.
module lidar_roi_polar_to_cartesian import lrpc_pkg::*; #(
   parameter int MAX_SCAN_POINTS = 4096,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [RANGE_W-1:0]        req_range_mm,
   input  logic [INDEX_W-1:0]        req_beam_index,
   input  logic                      req_scan_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [POS_W-1:0]   rsp_pos_x_mm,
   output logic signed [POS_W-1:0]   rsp_pos_y_mm,
   output logic                      rsp_in_roi,
   output logic                      rsp_in_wide,
   output logic                      rsp_out_last,
   input  logic                      csr_write,
   input  csr_index_type             csr_index,
   input  logic [CSR_W-1:0]          csr_data
);

   // Stage map: input stage, one cell per quotient bit, the angle stage, the
   // modulo cells, the quadrant fold, the CORDIC cells and the output stage.
   localparam int DIV_FIRST  = 1;
   localparam int ANG_STAGE  = DIV_FIRST + NUM_W;
   localparam int MOD_FIRST  = ANG_STAGE + 1;
   localparam int FOLD_STAGE = MOD_FIRST + MOD_STEPS;
   localparam int ROT_FIRST  = FOLD_STAGE + 1;
   localparam int OUT_STAGE  = ROT_FIRST + CORDIC_STAGES;
   localparam int STAGES     = OUT_STAGE + 1;

   // Configuration registers
   logic [RANGE_W-1:0]       floor_mm_ff;
   logic                     wide_mode_ff;
   logic [PPS_W-1:0]         pps_ff;
   logic signed [START_W-1:0] start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_mm_ff  <= RANGE_W'(100);
         wide_mode_ff <= 1'b0;
         pps_ff       <= PPS_W'(360);
         start_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_RANGE:   floor_mm_ff  <= csr_data[RANGE_W-1:0];
            CSR_WIDE_MODE:   wide_mode_ff <= csr_data[0];
            CSR_PPS:         pps_ff       <= csr_data[PPS_W-1:0];
            CSR_ANGLE_START: start_ff     <= csr_data[START_W-1:0];
            default:         ;
         endcase
      end
   end

   // A zero scan size counts as one beam; larger than the maximum saturates.
   logic [PPS_W-1:0] divisor;

   always_comb begin
      if (pps_ff == '0) begin
         divisor = PPS_W'(1);
      end else if (32'(pps_ff) > 32'(MAX_SCAN_POINTS)) begin
         divisor = PPS_W'(MAX_SCAN_POINTS);
      end else begin
         divisor = pps_ff;
      end
   end

   // Flow control. A stage loads when it is empty or its successor loads, so
   // bubbles close up behind a stalled output.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] load;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Input stage: scaled index as the dividend and the range flags.
   logic [NUM_W-1:0] num_ff;
   tag_type          in_tag_ff, in_tag_in;
   logic [RANGE_W-1:0] roi_limit;

   always_comb begin
      roi_limit          = wide_mode_ff ? RANGE_W'(ROI_LIMIT_WIDE) : RANGE_W'(ROI_LIMIT_NARROW);
      in_tag_in.range_mm = req_range_mm;
      in_tag_in.last     = req_scan_last;
      in_tag_in.roi_ok   = (req_range_mm > floor_mm_ff) && (req_range_mm < roi_limit);
      in_tag_in.wide_ok  = (req_range_mm > floor_mm_ff) && (req_range_mm < RANGE_W'(WIDE_LIMIT));
      in_tag_in.negate   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         num_ff    <= NUM_W'(FULL_TURN) * NUM_W'(req_beam_index);
         in_tag_ff <= in_tag_in;
      end
   end

   // Restoring divider, one quotient bit per cell. The dividend shifts out at
   // the top while quotient bits shift in at the bottom.
   logic [PPS_W-1:0] rem_c [NUM_W+1];
   logic [NUM_W-1:0] nq_c  [NUM_W+1];
   tag_type          dtag_c [NUM_W+1];

   assign rem_c[0]  = '0;
   assign nq_c[0]   = num_ff;
   assign dtag_c[0] = in_tag_ff;

   for (genvar j = 0; j < NUM_W; j++) begin : g_div
      lrpc_div_cell u_cell (
         .clock   (clock),
         .load    (load[DIV_FIRST + j]),
         .divisor (divisor),
         .rem_in  (rem_c[j]),
         .nq_in   (nq_c[j]),
         .tag_in  (dtag_c[j]),
         .rem_out (rem_c[j+1]),
         .nq_out  (nq_c[j+1]),
         .tag_out (dtag_c[j+1])
      );
   end

   // Angle stage: unwrapped angle for the region test, and the same angle
   // moved up by two full turns so that the modulo chain only sees positive
   // values, even for the most negative start angle the register can hold.
   logic signed [ANG_W-1:0] angle;
   logic signed [ANG_W-1:0] angle_up;
   logic [MOD_W-1:0]        ang_ff;
   tag_type                 ang_tag_ff, ang_tag_in;

   always_comb begin
      angle    = ANG_W'(start_ff) + signed'({2'b00, nq_c[NUM_W]});
      angle_up = angle + ANG_W'(2 * FULL_TURN);
      ang_tag_in        = dtag_c[NUM_W];
      ang_tag_in.roi_ok = dtag_c[NUM_W].roi_ok
                          && (angle >= ANG_W'(QUARTER_TURN))
                          && (angle <= ANG_W'(THREE_QUARTER));
   end

   always_ff @(posedge clock) begin
      if (load[ANG_STAGE]) begin
         ang_ff     <= angle_up[MOD_W-1:0];
         ang_tag_ff <= ang_tag_in;
      end
   end

   // Reduction modulo a full turn by conditional subtraction, largest multiple first.
   logic [MOD_W-1:0] mod_c  [MOD_STEPS+1];
   tag_type          mtag_c [MOD_STEPS+1];

   assign mod_c[0]  = ang_ff;
   assign mtag_c[0] = ang_tag_ff;

   for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
      lrpc_mod_cell #(
         .SHIFT (MOD_STEPS - 1 - j)
      ) u_cell (
         .clock   (clock),
         .load    (load[MOD_FIRST + j]),
         .ang_in  (mod_c[j]),
         .tag_in  (mtag_c[j]),
         .ang_out (mod_c[j+1]),
         .tag_out (mtag_c[j+1])
      );
   end

   // Quadrant fold into [-90, 90] degrees and the gain-scaled start vector.
   // The reduced angle lies below a full turn, so it is compared as unsigned.
   logic [T_W-1:0]         a_red;
   logic signed [T_W-1:0]  t_fold;
   logic                   fold_neg;
   logic [PROD_W-1:0]      gain_prod;
   logic [X0_W-1:0]        x_start;
   logic signed [XY_W-1:0] fx_ff;
   logic signed [Z_W-1:0]  fz_ff;
   tag_type                ftag_ff, ftag_in;

   always_comb begin
      a_red = mod_c[MOD_STEPS][T_W-1:0];
      if (a_red > T_W'(THREE_QUARTER)) begin
         t_fold   = a_red - T_W'(FULL_TURN);
         fold_neg = 1'b0;
      end else if (a_red >= T_W'(QUARTER_TURN)) begin
         t_fold   = a_red - T_W'(HALF_TURN);
         fold_neg = 1'b1;
      end else begin
         t_fold   = a_red;
         fold_neg = 1'b0;
      end
      gain_prod      = PROD_W'(mtag_c[MOD_STEPS].range_mm) * PROD_W'(GAIN_Q30);
      x_start        = X0_W'((gain_prod + PROD_W'(8192)) >> 14);
      ftag_in        = mtag_c[MOD_STEPS];
      ftag_in.negate = fold_neg;
   end

   always_ff @(posedge clock) begin
      if (load[FOLD_STAGE]) begin
         fx_ff   <= signed'(XY_W'(x_start));
         fz_ff   <= Z_W'(t_fold) <<< 16;
         ftag_ff <= ftag_in;
      end
   end

   // CORDIC rotation, one micro-rotation per cell.
   logic signed [XY_W-1:0] x_c [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] y_c [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  z_c [CORDIC_STAGES+1];
   tag_type                rtag_c [CORDIC_STAGES+1];

   assign x_c[0]    = fx_ff;
   assign y_c[0]    = '0;
   assign z_c[0]    = fz_ff;
   assign rtag_c[0] = ftag_ff;

   for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_rot
      lrpc_cordic_cell #(
         .STAGE (j)
      ) u_cell (
         .clock   (clock),
         .load    (load[ROT_FIRST + j]),
         .x_in    (x_c[j]),
         .y_in    (y_c[j]),
         .z_in    (z_c[j]),
         .tag_in  (rtag_c[j]),
         .x_out   (x_c[j+1]),
         .y_out   (y_c[j+1]),
         .z_out   (z_c[j+1]),
         .tag_out (rtag_c[j+1])
      );
   end

   // Output stage: undo the fold, round half up to millimetres and saturate.
   function automatic logic signed [POS_W-1:0] to_mm(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] r;
      r = (v + XY_W'(32768)) >>> 16;
      if (r > XY_W'(OUT_MAX)) begin
         return POS_W'(OUT_MAX);
      end else if (r < -XY_W'(OUT_MAX)) begin
         return -POS_W'(OUT_MAX);
      end else begin
         return r[POS_W-1:0];
      end
   endfunction

   logic signed [XY_W-1:0] x_end, y_end;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic                    roi_ff, wide_ff, last_ff;
   tag_type                 end_tag;

   always_comb begin
      end_tag = rtag_c[CORDIC_STAGES];
      x_end   = end_tag.negate ? -x_c[CORDIC_STAGES] : x_c[CORDIC_STAGES];
      y_end   = end_tag.negate ? -y_c[CORDIC_STAGES] : y_c[CORDIC_STAGES];
   end

   always_ff @(posedge clock) begin
      if (load[OUT_STAGE]) begin
         pos_x_ff <= to_mm(y_end);
         pos_y_ff <= to_mm(-x_end);
         roi_ff   <= end_tag.roi_ok;
         wide_ff  <= end_tag.wide_ok;
         last_ff  <= end_tag.last;
      end
   end

   assign rsp_pos_x_mm = pos_x_ff;
   assign rsp_pos_y_mm = pos_y_ff;
   assign rsp_in_roi   = roi_ff;
   assign rsp_in_wide  = wide_ff;
   assign rsp_out_last = last_ff;

endmodule

@@ rtl/core/lrpc_div_cell.sv @@
// One restoring division step: brings down one numerator bit, shifts in one quotient bit.
module lrpc_div_cell import lrpc_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic [PPS_W-1:0] divisor,
   input  logic [PPS_W-1:0] rem_in,
   input  logic [NUM_W-1:0] nq_in,
   input  tag_type          tag_in,
   output logic [PPS_W-1:0] rem_out,
   output logic [NUM_W-1:0] nq_out,
   output tag_type          tag_out
);

   logic [PPS_W-1:0] rem_ff, rem_in_next;
   logic [NUM_W-1:0] nq_ff, nq_in_next;
   tag_type          tag_ff;
   logic [REM_W-1:0] trial;
   logic [REM_W-1:0] diff;
   logic             fits;

   always_comb begin
      trial       = {rem_in, nq_in[NUM_W-1]};
      diff        = trial - {1'b0, divisor};
      fits        = trial >= {1'b0, divisor};
      rem_in_next = fits ? diff[PPS_W-1:0] : trial[PPS_W-1:0];
      nq_in_next  = {nq_in[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in_next;
         nq_ff  <= nq_in_next;
         tag_ff <= tag_in;
      end
   end

   assign rem_out = rem_ff;
   assign nq_out  = nq_ff;
   assign tag_out = tag_ff;

endmodule

@@ rtl/core/lrpc_mod_cell.sv @@
// Subtracts one full turn shifted left by SHIFT when the angle is at least that large.
module lrpc_mod_cell import lrpc_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             load,
   input  logic [MOD_W-1:0] ang_in,
   input  tag_type          tag_in,
   output logic [MOD_W-1:0] ang_out,
   output tag_type          tag_out
);

   localparam logic [MOD_W-1:0] STEP = MOD_W'(FULL_TURN) << SHIFT;

   logic [MOD_W-1:0] ang_ff, ang_in_next;
   tag_type          tag_ff;

   assign ang_in_next = (ang_in >= STEP) ? ang_in - STEP : ang_in;

   always_ff @(posedge clock) begin
      if (load) begin
         ang_ff <= ang_in_next;
         tag_ff <= tag_in;
      end
   end

   assign ang_out = ang_ff;
   assign tag_out = tag_ff;

endmodule

@@ rtl/core/lrpc_cordic_cell.sv @@
// One CORDIC rotation step with floor shifts by STAGE.
module lrpc_cordic_cell import lrpc_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic signed [XY_W-1:0] x_in,
   input  logic signed [XY_W-1:0] y_in,
   input  logic signed [Z_W-1:0]  z_in,
   input  tag_type                tag_in,
   output logic signed [XY_W-1:0] x_out,
   output logic signed [XY_W-1:0] y_out,
   output logic signed [Z_W-1:0]  z_out,
   output tag_type                tag_out
);

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_TAB[STAGE]);

   logic signed [XY_W-1:0] x_ff, y_ff, x_in_next, y_in_next, dx, dy;
   logic signed [Z_W-1:0]  z_ff, z_in_next;
   tag_type                tag_ff;

   always_comb begin
      dx = y_in >>> STAGE;
      dy = x_in >>> STAGE;
      if (!z_in[Z_W-1]) begin
         x_in_next = x_in - dx;
         y_in_next = y_in + dy;
         z_in_next = z_in - ATAN;
      end else begin
         x_in_next = x_in + dx;
         y_in_next = y_in - dy;
         z_in_next = z_in + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff   <= x_in_next;
         y_ff   <= y_in_next;
         z_ff   <= z_in_next;
         tag_ff <= tag_in;
      end
   end

   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign z_out   = z_ff;
   assign tag_out = tag_ff;

endmodule

@@ tb/sv/tb_lidar_roi_polar_to_cartesian.sv @@
`timescale 1ns / 1ps

// Directed and random testbench for the beam converter. A predictor inside this
// module mirrors the beam angle, CORDIC rotation and region flags. It keeps its
// own copy of the registers and queues one expected point per accepted word.
module tb_lidar_roi_polar_to_cartesian;
   import lrpc_pkg::*;

   localparam int MAX_POINTS = 4096;
   localparam int STAGES     = 16;
   // The drain wait spans the pipeline plus a margin that covers stages still busy.
   localparam int DRAIN_CYCLES = 45 + STAGES + 20;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x_mm;
      logic signed [POS_W-1:0] pos_y_mm;
      logic                    in_roi;
      logic                    in_wide;
      logic                    out_last;
   } point_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [RANGE_W-1:0]       req_range_mm;
   logic [INDEX_W-1:0]       req_beam_index;
   logic                     req_scan_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [POS_W-1:0]  rsp_pos_x_mm;
   logic signed [POS_W-1:0]  rsp_pos_y_mm;
   logic                     rsp_in_roi;
   logic                     rsp_in_wide;
   logic                     rsp_out_last;
   logic                     csr_write;
   csr_index_type            csr_index;
   logic [CSR_W-1:0]         csr_data;

   // Predictor's copy of the registers, held at their reset values to begin with.
   logic [RANGE_W-1:0]       floor_mm = 16'd100;
   logic                     wide_sel = 1'b0;
   logic [PPS_W-1:0]         scan_points = 13'd360;
   logic signed [START_W-1:0] start_cdeg = '0;

   point_type expected_points[$];
   bit        failed = 0;
   bit        quiet = 0;   // when set, neither side idles

   lidar_roi_polar_to_cartesian #(
      .MAX_SCAN_POINTS(MAX_POINTS),
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_range_mm(req_range_mm), .req_beam_index(req_beam_index),
      .req_scan_last(req_scan_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x_mm(rsp_pos_x_mm), .rsp_pos_y_mm(rsp_pos_y_mm),
      .rsp_in_roi(rsp_in_roi), .rsp_in_wide(rsp_in_wide),
      .rsp_out_last(rsp_out_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Rounds a Q16 value to millimetres, half up, and clamps it to the output range.
   function automatic logic signed [POS_W-1:0] round_mm(longint q16);
      longint r;
      r = (q16 + 32768) >>> 16;
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < -OUT_MAX) r = -OUT_MAX;
      return r[POS_W-1:0];
   endfunction

   // Works out the Cartesian point and flags that one beam should produce.
   function automatic point_type convert_beam(logic [RANGE_W-1:0] range_mm,
                                              logic [INDEX_W-1:0] index, logic last);
      point_type p;
      longint pps, angle, a, t, x, y, z, dx, dy;
      bit negate;
      int limit;
      pps = scan_points;
      if (pps == 0) pps = 1;
      if (pps > MAX_POINTS) pps = MAX_POINTS;
      angle = longint'(start_cdeg) + (longint'(FULL_TURN) * index) / pps;

      // Reduce to one turn, then fold into the quarter either side of zero.
      a = angle % FULL_TURN;
      if (a < 0) a += FULL_TURN;
      negate = 0;
      if (a > THREE_QUARTER) t = a - FULL_TURN;
      else if (a >= QUARTER_TURN) begin
         t = a - HALF_TURN;
         negate = 1;
      end else t = a;

      x = (longint'(range_mm) * longint'(GAIN_Q30) + 8192) >>> 14;
      y = 0;
      z = t * 65536;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ATAN_TAB[i];
         end else begin
            x += dx;
            y -= dy;
            z += ATAN_TAB[i];
         end
      end
      if (negate) begin
         x = -x;
         y = -y;
      end

      limit = wide_sel ? ROI_LIMIT_WIDE : ROI_LIMIT_NARROW;
      p.pos_x_mm = round_mm(y);
      p.pos_y_mm = round_mm(-x);
      p.in_roi   = range_mm > floor_mm && range_mm < limit
                   && angle >= QUARTER_TURN && angle <= THREE_QUARTER;
      p.in_wide  = range_mm > floor_mm && range_mm < WIDE_LIMIT;
      p.out_last = last;
      return p;
   endfunction

   // Result side: random stalls except in quiet stretches.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(99) < 31);
   end

   // Each accepted result is held against the oldest expectation, field by field.
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d", $time, rsp_pos_x_mm, rsp_pos_y_mm);
            failed = 1;
         end else begin
            e = expected_points.pop_front();
            if (rsp_pos_x_mm !== e.pos_x_mm) begin
               $display("%0t: pos_x_mm expected %0d actual %0d", $time, e.pos_x_mm, rsp_pos_x_mm);
               failed = 1;
            end
            if (rsp_pos_y_mm !== e.pos_y_mm) begin
               $display("%0t: pos_y_mm expected %0d actual %0d", $time, e.pos_y_mm, rsp_pos_y_mm);
               failed = 1;
            end
            if (rsp_in_roi !== e.in_roi) begin
               $display("%0t: in_roi expected %0b actual %0b", $time, e.in_roi, rsp_in_roi);
               failed = 1;
            end
            if (rsp_in_wide !== e.in_wide) begin
               $display("%0t: in_wide expected %0b actual %0b", $time, e.in_wide, rsp_in_wide);
               failed = 1;
            end
            if (rsp_out_last !== e.out_last) begin
               $display("%0t: out_last expected %0b actual %0b", $time, e.out_last, rsp_out_last);
               failed = 1;
            end
         end
      end
   end

   // Sends one beam word. We are at a falling edge on entry and on return. The
   // valid stays high on return; the next call or the caller takes it down.
   task automatic send_beam(logic [RANGE_W-1:0] range_mm, logic [INDEX_W-1:0] index,
                            logic last);
      while (!quiet && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_range_mm   <= range_mm;
      req_beam_index <= index;
      req_scan_last  <= last;
      do @(posedge clock); while (req_stall);
      expected_points.insert(expected_points.size(), convert_beam(range_mm, index, last));
      @(negedge clock);
   endtask

   // Waits for the pipeline to empty, then writes one register and mirrors it.
   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      req_valid <= 1'b0;
      wait (expected_points.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MIN_RANGE:   floor_mm    = value[RANGE_W-1:0];
         CSR_WIDE_MODE:   wide_sel    = value[0];
         CSR_PPS:         scan_points = value[PPS_W-1:0];
         CSR_ANGLE_START: start_cdeg  = value[START_W-1:0];
         default: ;
      endcase
   endtask

   // Range boundaries, the ROI angle edges and the extremes of every field.
   task automatic test_directed_edges();
      send_beam(16'd0, 12'd0, 1'b0);
      send_beam(16'hFFFF, 12'd0, 1'b0);
      send_beam(16'd100, 12'd180, 1'b0);
      send_beam(16'd101, 12'd180, 1'b0);
      send_beam(16'd1399, 12'd90, 1'b0);
      send_beam(16'd1400, 12'd90, 1'b0);
      send_beam(16'd1000, 12'd89, 1'b0);
      send_beam(16'd1000, 12'd270, 1'b0);
      send_beam(16'd1000, 12'd271, 1'b0);
      send_beam(16'd2499, 12'd45, 1'b0);
      send_beam(16'd2500, 12'd135, 1'b0);
      // An index beyond the scan grows the angle past a full turn.
      send_beam(16'd1200, 12'd4095, 1'b1);
      send_beam(16'hFFFF, 12'd315, 1'b1);
   endtask

   // The wide ROI limit sits at 2000 mm instead of 1400 mm.
   task automatic test_wide_mode();
      write_reg(CSR_WIDE_MODE, 17'd1);
      send_beam(16'd1999, 12'd180, 1'b0);
      send_beam(16'd2000, 12'd180, 1'b0);
      send_beam(16'd1500, 12'd90, 1'b1);
   endtask

   // A scan size of zero counts as one beam; sizes above the maximum saturate.
   task automatic test_scan_size();
      write_reg(CSR_PPS, 17'd0);
      send_beam(16'd500, 12'd0, 1'b0);
      send_beam(16'd500, 12'd1, 1'b0);
      send_beam(16'd500, 12'd4095, 1'b1);
      write_reg(CSR_PPS, 17'h1FFF);
      send_beam(16'd1500, 12'd1024, 1'b0);
      send_beam(16'd1500, 12'd3072, 1'b1);
      write_reg(CSR_PPS, 17'd4097);
      send_beam(16'd1500, 12'd2048, 1'b0);
   endtask

   // Start angle at both signed extremes, and the minimum range at both ends.
   task automatic test_start_and_min();
      write_reg(CSR_ANGLE_START, 17'h10000);
      send_beam(16'd1000, 12'd0, 1'b0);
      write_reg(CSR_ANGLE_START, 17'h0FFFF);
      send_beam(16'd1000, 12'd4095, 1'b0);
      write_reg(CSR_MIN_RANGE, 17'hFFFF);
      send_beam(16'hFFFF, 12'd10, 1'b0);
      write_reg(CSR_MIN_RANGE, 17'd0);
      send_beam(16'd1, 12'd0, 1'b1);
      send_beam(16'd0, 12'd0, 1'b0);
   endtask

   // Random scans: mostly short ranges near the limits, some across the full field.
   task automatic test_random_scans(int count);
      logic [RANGE_W-1:0] range_mm;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(9);
         if (pick < 6) range_mm = RANGE_W'($urandom_range(3000));
         else range_mm = RANGE_W'($urandom);
         send_beam(range_mm, INDEX_W'($urandom_range(4095)), $urandom_range(15) == 0);
      end
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         write_reg(CSR_MIN_RANGE, CSR_W'($urandom_range(phase == 0 ? 0 : 600)));
         write_reg(CSR_WIDE_MODE, CSR_W'($urandom_range(1)));
         write_reg(CSR_PPS, CSR_W'((phase % 3 == 0) ? $urandom_range(8191)
                                                     : $urandom_range(1, 4096)));
         write_reg(CSR_ANGLE_START, CSR_W'($urandom_range(72000) - 36000));
         // The second phase runs with no idling on either side.
         quiet = (phase == 1);
         test_random_scans(240);
         quiet = 0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_range_mm   = '0;
      req_beam_index = '0;
      req_scan_last  = 1'b0;
      rsp_stall      = 1'b0;
      csr_write      = 1'b0;
      csr_index      = CSR_MIN_RANGE;
      csr_data       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_wide_mode();
      test_scan_size();
      test_start_and_min();
      test_random_settings();
      req_valid <= 1'b0;

      wait (expected_points.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_points.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
